@@ hw/rtl/exlx_pkg.sv @@
`timescale 1ns / 1ps

package exlx_pkg;

    // Lexer states
    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDENT   = 3'd1;
    localparam logic [2:0] ST_COMMENT = 3'd2;
    localparam logic [2:0] ST_INT     = 3'd3;
    localparam logic [2:0] ST_FRAC    = 3'd4;
    localparam logic [2:0] ST_EXP0    = 3'd5;
    localparam logic [2:0] ST_EXP1    = 3'd6;

    // Token kinds (0..12 are the operator characters in table order)
    localparam logic [4:0] K_IDENT  = 5'd13;
    localparam logic [4:0] K_INT    = 5'd14;
    localparam logic [4:0] K_REAL   = 5'd15;
    localparam logic [4:0] K_END    = 5'd16;
    localparam logic [4:0] K_BADCH  = 5'd17;
    localparam logic [4:0] K_BADNUM = 5'd18;

    localparam int NUM_OPS = 13;
    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h28, 8'h29,
        8'h3B, 8'h2C, 8'h3D, 8'h5B, 8'h5D, 8'h2E
    };

    localparam logic [7:0] CH_END = 8'hFF;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_E_LO = 8'h65;
    localparam logic [7:0] CH_E_UP = 8'h45;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int DEF_MAX_TOKEN_LEN = 255;

    // Token queue depth: two slots must be free to take a byte
    localparam int TQ_DEPTH = 4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  length;
        logic [31:0] value;
        logic        ovf;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [2:0]  state;
        logic [7:0]  count;
        logic [31:0] acc;
        logic        ovf;
    } lex_ctx_t;

    typedef struct packed {
        lex_ctx_t   ctx;
        logic [1:0] n_tok;
        token_t     tok0;
        token_t     tok1;
    } step_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

@@ hw/rtl/exlx_step.sv @@
`timescale 1ns / 1ps

module exlx_step
    import exlx_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)
(
    input  logic [7:0] ch,
    input  lex_ctx_t   ctx,
    output step_res_t  res
);

    localparam int LEN_CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [7:0] LEN_CAP = LEN_CAP_I[7:0];

    logic       dig, alpha, op_hit;
    logic [3:0] op_idx;
    logic [7:0] grown;
    logic [35:0] mac;
    logic [31:0] acc_add;
    logic        ovf_add;

    // init pass
    logic     i_emit;
    token_t   i_tok;
    lex_ctx_t i_ctx;

    // first pass
    logic     fall;
    logic     f_emit;
    token_t   f_tok;
    lex_ctx_t f_ctx;

    assign dig   = is_digit(ch);
    assign alpha = is_alpha(ch);

    always_comb
    begin
        op_hit = 1'b0;
        op_idx = '0;
        for (int i = 0; i < NUM_OPS; i++)
        begin
            if (!op_hit && OP_CHARS[i] == ch)
            begin
                op_hit = 1'b1;
                op_idx = 4'(i);
            end
        end
    end

    assign grown = (ctx.count < LEN_CAP) ? ctx.count + 8'd1 : ctx.count;

    // acc * 10 + digit, saturating at 32 bits
    assign mac = {1'b0, ctx.acc, 3'b000} + {3'b000, ctx.acc, 1'b0} + {32'd0, ch[3:0]};
    assign ovf_add = |mac[35:32];
    assign acc_add = ovf_add ? 32'hFFFF_FFFF : mac[31:0];

    // The byte seen from init, with cleared token context
    always_comb
    begin
        i_emit = 1'b0;
        i_tok  = '{kind: K_BADCH, length: 8'd1, value: 32'd0, ovf: 1'b0, last: 1'b1};
        i_ctx  = '{state: ST_INIT, count: 8'd0, acc: 32'd0, ovf: 1'b0};
        if (dig)
        begin
            i_ctx.state = ST_INT;
            i_ctx.count = 8'd1;
            i_ctx.acc   = {28'd0, ch[3:0]};
        end
        else if (ch == CH_END)
        begin
            i_emit = 1'b1;
            i_tok.kind = K_END;
        end
        else if (op_hit)
        begin
            i_emit = 1'b1;
            i_tok.kind = {1'b0, op_idx};
        end
        else if (ch == CH_SP || ch == CH_TAB || ch == CH_NL)
        begin
            i_emit = 1'b0;
        end
        else if (ch == CH_HASH)
        begin
            i_ctx.state = ST_COMMENT;
        end
        else if (alpha)
        begin
            i_ctx.state = ST_IDENT;
            i_ctx.count = 8'd1;
        end
        else
        begin
            i_emit = 1'b1;
        end
    end

    always_comb
    begin
        fall   = 1'b0;
        f_emit = 1'b0;
        f_tok  = '{kind: K_REAL, length: ctx.count, value: 32'd0, ovf: 1'b0, last: 1'b0};
        f_ctx  = ctx;
        case (ctx.state)
            ST_INIT:
            begin
                fall = 1'b1;
            end
            ST_IDENT:
            begin
                if (alpha || dig || ch == CH_US)
                    f_ctx.count = grown;
                else
                begin
                    fall = 1'b1;
                    f_emit = 1'b1;
                    f_tok.kind = K_IDENT;
                end
            end
            ST_COMMENT:
            begin
                if (ch == CH_NL)
                    f_ctx.state = ST_INIT;
            end
            ST_INT:
            begin
                if (dig)
                begin
                    f_ctx.count = grown;
                    f_ctx.acc   = acc_add;
                    f_ctx.ovf   = ctx.ovf | ovf_add;
                end
                else if (ch == CH_DOT)
                begin
                    f_ctx.count = grown;
                    f_ctx.state = ST_FRAC;
                end
                else if (ch == CH_E_LO || ch == CH_E_UP)
                begin
                    f_ctx.count = grown;
                    f_ctx.state = ST_EXP0;
                end
                else
                begin
                    fall = 1'b1;
                    f_emit = 1'b1;
                    f_tok.kind  = K_INT;
                    f_tok.value = ctx.acc;
                    f_tok.ovf   = ctx.ovf;
                end
            end
            ST_FRAC:
            begin
                if (dig)
                    f_ctx.count = grown;
                else if (ch == CH_E_LO || ch == CH_E_UP)
                begin
                    f_ctx.count = grown;
                    f_ctx.state = ST_EXP0;
                end
                else
                begin
                    fall = 1'b1;
                    f_emit = 1'b1;
                end
            end
            ST_EXP0:
            begin
                if (dig || ch == CH_PLUS || ch == CH_MINUS)
                begin
                    f_ctx.count = grown;
                    f_ctx.state = ST_EXP1;
                end
                else
                begin
                    fall = 1'b1;
                    f_emit = 1'b1;
                    f_tok.kind = K_BADNUM;
                end
            end
            ST_EXP1:
            begin
                if (dig)
                    f_ctx.count = grown;
                else
                begin
                    fall = 1'b1;
                    f_emit = 1'b1;
                end
            end
            default:
            begin
                fall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res.ctx   = fall ? i_ctx : f_ctx;
        res.n_tok = {1'b0, f_emit} + {1'b0, fall & i_emit};
        res.tok0  = f_emit ? f_tok : i_tok;
        res.tok0.last = !(f_emit && fall && i_emit);
        res.tok1  = i_tok;
    end

endmodule

@@ hw/rtl/exlx_tokq.sv @@
`timescale 1ns / 1ps

module exlx_tokq
    import exlx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  token_t     push0,
    input  token_t     push1,
    output logic       room2,
    output logic       head_valid,
    input  logic       pop,
    output token_t     head
);

    localparam int PW = $clog2(TQ_DEPTH);
    localparam int CW = $clog2(TQ_DEPTH + 1);

    token_t        mem [TQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;
    logic [PW-1:0] wr_ptr_p1;

    assign do_pop     = pop && (cnt_reg != '0);
    assign wr_ptr_p1  = wr_ptr_reg + PW'(1);
    assign room2      = (cnt_reg <= CW'(TQ_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(do_pop);
    assign cnt_next    = cnt_reg + CW'(push_n) - CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            mem[wr_ptr_p1] <= push1;
    end

    // pushing into a queue without two free slots loses tokens
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (cnt_reg <= CW'(TQ_DEPTH - 2)))
        else $error("token queue overrun");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TQ_DEPTH))
        else $error("token queue count out of range");

endmodule

@@ hw/rtl/expression_lexer.sv @@
`timescale 1ns / 1ps

// Byte-serial lexer for arithmetic expressions. Each request on the input
// channel carries one byte (0xFF marks end of input); each request on the
// output channel carries one token: operator kinds 0-12 (+ - * / ^ ( ) ; , = [ ] .),
// identifier, integer with saturating 32-bit value and overflow flag, real,
// end, bad character or bad number, with its length (saturating) and a last
// flag on the final token a byte produces. A byte that terminates a token is
// rescanned from the init state in the same cycle, so it may produce two
// tokens. The lexer step is combinational logic between the state registers
// and a four-entry token queue: a byte is taken every cycle as long as the
// queue has two free slots, so bytes giving at most one token stream at one
// per cycle, and a byte giving two tokens pushes both into the queue at once.
// Tokens are registered in the queue before they reach the output. Whitespace
// and comments produce no tokens.
module expression_lexer
    import exlx_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [7:0]  token_length,
    output logic [31:0] int_value,
    output logic        int_overflow,
    output logic        last
);

    lex_ctx_t  ctx_reg, ctx_next;
    step_res_t step;
    logic      take;
    logic      room2;
    token_t    head;
    logic [1:0] push_n;

    assign in_ready = room2;
    assign take     = in_valid && in_ready;
    assign push_n   = take ? step.n_tok : 2'd0;

    exlx_step #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_step (
        .ch  (ch),
        .ctx (ctx_reg),
        .res (step)
    );

    // lexer context only advances on an accepted byte
    assign ctx_next = take ? step.ctx : ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_reg <= '{state: ST_INIT, count: 8'd0, acc: 32'd0, ovf: 1'b0};
        else
            ctx_reg <= ctx_next;
    end

    exlx_tokq u_tokq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (step.tok0),
        .push1      (step.tok1),
        .room2      (room2),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_length = head.length;
    assign int_value    = head.value;
    assign int_overflow = head.ovf;
    assign last         = head.last;

    // overflow only ever comes with a saturated value
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && int_overflow) |-> (token_kind == K_INT) && (int_value == 32'hFFFF_FFFF))
        else $error("overflow flag without saturated integer");

    // only integer tokens carry a value
    a_val_int_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind != K_INT) |-> (int_value == 32'd0) && !int_overflow)
        else $error("value on non-integer token");

    // every token has at least one character
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_length != 8'd0))
        else $error("zero-length token");

    // a token that ends its token context returns the lexer to a clean start
    a_ctx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg.state == ST_INIT || ctx_reg.state == ST_COMMENT)
            |-> (ctx_reg.count == 8'd0) && (ctx_reg.acc == 32'd0) && !ctx_reg.ovf)
        else $error("stale token context in init state");

endmodule
